### rtl/bsc_pkg.sv
// Shared types and constants for the barometer compensation core.
// Used by every module in rtl/; depends on nothing.
package bsc_pkg;

  localparam int D_W      = 24;  // raw conversion width
  localparam int CAL_W    = 16;  // factory word width
  localparam int CFG_IDX_W = 3;
  localparam int DT_W     = 25;  // D2 - C5*256
  localparam int MUL_W    = 41;  // dT times a factory word
  localparam int DD_W     = 50;  // dT squared
  localparam int TEMP_W   = 19;
  localparam int DTC_W    = 18;  // TEMP - 2000 before second order
  localparam int T2_W     = 18;
  localparam int FIRST_W  = 36;  // first-order OFF and SENS
  localparam int SQ_W     = 35;  // temperature squares
  localparam int CORR_W   = 38;  // OFF2 and SENS2
  localparam int COMP_W   = 40;  // final OFF and SENS
  localparam int SPLIT_W  = 20;  // low slice of SENS for the split multiply
  localparam int PLO_W    = 44;
  localparam int PHI_W    = 45;
  localparam int PROD_W   = 66;
  localparam int P_W      = 32;

  localparam int TEMP_SHIFT = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int T2_SHIFT   = 31;
  localparam int P_SHIFT_A  = 21;
  localparam int P_SHIFT_B  = 15;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -19'sd1500;
  localparam logic signed [TEMP_W-1:0] COLD_OFS  = 19'sd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSURE_SENSITIVITY   = 3'd0,
    REG_PRESSURE_OFFSET        = 3'd1,
    REG_SENSITIVITY_TEMP_COEFF = 3'd2,
    REG_OFFSET_TEMP_COEFF      = 3'd3,
    REG_REFERENCE_TEMPERATURE  = 3'd4,
    REG_TEMPERATURE_COEFF      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_coeff;
  } cal_t;

  // First-order results handed to the second-order section
  typedef struct packed {
    logic [D_W-1:0]            d1;
    logic signed [TEMP_W-1:0]  temp;
    logic signed [DTC_W-1:0]   dtc;
    logic signed [TEMP_W-1:0]  dcold;
    logic [T2_W-1:0]           t2;
    logic signed [FIRST_W-1:0] off;
    logic signed [FIRST_W-1:0] sens;
    logic                      low;
    logic                      cold;
  } first_t;

  // Fully compensated terms handed to the pressure section
  typedef struct packed {
    logic [D_W-1:0]           d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [COMP_W-1:0] off;
    logic signed [COMP_W-1:0] sens;
  } comp_t;

endpackage

### rtl/baro_sensor_compensation_core.sv
// Barometer second-order temperature compensation core, top level.
// Depends on bsc_pkg, bsc_front, bsc_second and bsc_press.
//
// Usage:
//   Load the six factory words through cfg_write/cfg_index/cfg_data while
//   the core is idle; each write takes effect at the clock edge, indexes 6
//   and 7 are ignored. Reset clears all six words to zero.
//   Present a raw pressure/temperature pair on the input channel
//   (in_valid/in_ready). One transaction leaves on the output channel
//   (out_valid/out_ready) for every input transaction, in order.
//   Pipeline: seven register stages (dT, dT products, first order, squares,
//   second order, split D1*SENS product, output register); the first is
//   loaded at the input transaction.
//   Throughput: one pair per cycle while out_ready is high (see Stall).
//   Stall: when out_ready is low, stages fill up behind the output register
//   and in_ready drops only once every stage holds a transaction; nothing
//   is dropped or repeated.
//   Reset (rst, synchronous): empties the pipeline and clears the words.
module baro_sensor_compensation_core import bsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CAL_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [D_W-1:0]           raw_pressure,
  input  logic [D_W-1:0]           raw_temperature,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] temperature_centideg,
  output logic signed [P_W-1:0]    pressure_pa
);

  cal_t   cal;
  logic   first_valid, first_ready;
  first_t first_data;
  logic   comp_valid, comp_ready;
  comp_t  comp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRESSURE_SENSITIVITY:   cal.pressure_sensitivity   <= cfg_data;
        REG_PRESSURE_OFFSET:        cal.pressure_offset        <= cfg_data;
        REG_SENSITIVITY_TEMP_COEFF: cal.sensitivity_temp_coeff <= cfg_data;
        REG_OFFSET_TEMP_COEFF:      cal.offset_temp_coeff      <= cfg_data;
        REG_REFERENCE_TEMPERATURE:  cal.reference_temperature  <= cfg_data;
        REG_TEMPERATURE_COEFF:      cal.temperature_coeff      <= cfg_data;
        default: ;
      endcase
    end
  end

  bsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cal             (cal),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .out_valid       (first_valid),
    .out_ready       (first_ready),
    .out_data        (first_data)
  );

  bsc_second u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (first_valid),
    .in_ready  (first_ready),
    .in_data   (first_data),
    .out_valid (comp_valid),
    .out_ready (comp_ready),
    .out_data  (comp_data)
  );

  bsc_press u_press (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (comp_valid),
    .in_ready             (comp_ready),
    .in_data              (comp_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .temperature_centideg (temperature_centideg),
    .pressure_pa          (pressure_pa)
  );

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A free output stage frees the whole chain
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // Input back-pressure only when a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty output register");

endmodule

### rtl/bsc_front.sv
// First-order compensation: dT, the four dT products, then TEMP, OFF, SENS.
// Three register stages; depends on bsc_pkg.
module bsc_front import bsc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cal_t            cal,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [D_W-1:0]  raw_pressure,
  input  logic [D_W-1:0]  raw_temperature,
  output logic            out_valid,
  input  logic            out_ready,
  output first_t          out_data
);

  logic                     s1_v, s2_v, s3_v;
  logic                     s1_rdy, s2_rdy, s3_rdy;
  logic [D_W-1:0]           s1_d1, s2_d1;
  logic signed [DT_W-1:0]   s1_dt, s1_dt_next;
  logic signed [MUL_W-1:0]  s2_t6, s2_off, s2_sens;
  logic signed [MUL_W-1:0]  s2_t6_next, s2_off_next, s2_sens_next;
  logic signed [DD_W-1:0]   s2_dd, s2_dd_next;
  logic signed [MUL_W-1:0]  t6_sh, off_sh, sens_sh;
  first_t                   s3, s3_next;

  assign s3_rdy   = !s3_v || out_ready;
  assign s2_rdy   = !s2_v || s3_rdy;
  assign s1_rdy   = !s1_v || s2_rdy;
  assign in_ready = s1_rdy;

  assign s1_dt_next = $signed({1'b0, raw_temperature})
                    - $signed({1'b0, cal.reference_temperature, 8'b0});

  assign s2_t6_next   = s1_dt * $signed({1'b0, cal.temperature_coeff});
  assign s2_off_next  = s1_dt * $signed({1'b0, cal.offset_temp_coeff});
  assign s2_sens_next = s1_dt * $signed({1'b0, cal.sensitivity_temp_coeff});
  assign s2_dd_next   = s1_dt * s1_dt;

  assign t6_sh   = s2_t6 >>> TEMP_SHIFT;
  assign off_sh  = s2_off >>> OFF_SHIFT;
  assign sens_sh = s2_sens >>> SENS_SHIFT;

  always_comb begin
    s3_next       = '0;
    s3_next.d1    = s2_d1;
    s3_next.dtc   = t6_sh[DTC_W-1:0];
    s3_next.temp  = TEMP_W'(s3_next.dtc) + TEMP_BASE;
    s3_next.dcold = s3_next.temp + COLD_OFS;
    s3_next.t2    = s2_dd[T2_SHIFT +: T2_W];
    s3_next.off   = $signed({4'b0, cal.pressure_offset, 16'b0})
                  + $signed(off_sh[FIRST_W-1:0]);
    s3_next.sens  = $signed({5'b0, cal.pressure_sensitivity, 15'b0})
                  + $signed(sens_sh[FIRST_W-1:0]);
    s3_next.low   = s3_next.dtc[DTC_W-1];
    s3_next.cold  = s3_next.temp < TEMP_COLD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (s1_rdy) s1_v <= in_valid;
      if (s2_rdy) s2_v <= s1_v;
      if (s3_rdy) s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_d1 <= raw_pressure;
      s1_dt <= s1_dt_next;
    end
    if (s2_rdy) begin
      s2_d1   <= s1_d1;
      s2_t6   <= s2_t6_next;
      s2_off  <= s2_off_next;
      s2_sens <= s2_sens_next;
      s2_dd   <= s2_dd_next;
    end
    if (s3_rdy) s3 <= s3_next;
  end

  assign out_valid = s3_v;
  assign out_data  = s3;

endmodule

### rtl/bsc_second.sv
// Second-order correction below 20.00 degrees, extra term below -15.00.
// Two register stages (squares, then corrections); depends on bsc_pkg.
module bsc_second import bsc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  first_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output comp_t  out_data
);

  logic                       s4_v, s5_v;
  logic                       s4_rdy, s5_rdy;
  first_t                     s4;
  logic [SQ_W-1:0]            s4_f, s4_g;
  logic signed [2*DTC_W-1:0]  f_full;
  logic signed [2*TEMP_W-1:0] g_full;
  logic [CORR_W-1:0]          five_f, seven_g, eleven_g, off2, sens2;
  comp_t                      s5, s5_next;

  assign s5_rdy   = !s5_v || out_ready;
  assign s4_rdy   = !s4_v || s5_rdy;
  assign in_ready = s4_rdy;

  assign f_full = in_data.dtc * in_data.dtc;
  assign g_full = in_data.dcold * in_data.dcold;

  // Constant multiples by shift, add and subtract
  assign five_f   = (CORR_W'(s4_f) << 2) + CORR_W'(s4_f);
  assign seven_g  = (CORR_W'(s4_g) << 3) - CORR_W'(s4_g);
  assign eleven_g = (CORR_W'(s4_g) << 3) + (CORR_W'(s4_g) << 1) + CORR_W'(s4_g);
  assign off2     = (five_f >> 1) + (s4.cold ? seven_g : '0);
  assign sens2    = (five_f >> 2) + (s4.cold ? (eleven_g >> 1) : '0);

  always_comb begin
    s5_next.d1 = s4.d1;
    if (s4.low) begin
      s5_next.temp = s4.temp - $signed({1'b0, s4.t2});
      s5_next.off  = COMP_W'(s4.off) - $signed({2'b0, off2});
      s5_next.sens = COMP_W'(s4.sens) - $signed({2'b0, sens2});
    end else begin
      s5_next.temp = s4.temp;
      s5_next.off  = COMP_W'(s4.off);
      s5_next.sens = COMP_W'(s4.sens);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else begin
      if (s4_rdy) s4_v <= in_valid;
      if (s5_rdy) s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      s4   <= in_data;
      s4_f <= f_full[SQ_W-1:0];
      s4_g <= g_full[SQ_W-1:0];
    end
    if (s5_rdy) s5 <= s5_next;
  end

  assign out_valid = s5_v;
  assign out_data  = s5;

endmodule

### rtl/bsc_press.sv
// Pressure output: D1*SENS as two split products, then shift and subtract.
// Two register stages, the last one is the output register; depends on bsc_pkg.
module bsc_press import bsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  comp_t                    in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] temperature_centideg,
  output logic signed [P_W-1:0]    pressure_pa
);

  logic                     s6_v, s7_v;
  logic                     s6_rdy, s7_rdy;
  logic [PLO_W-1:0]         s6_lo, s6_lo_next;
  logic signed [PHI_W-1:0]  s6_hi, s6_hi_next;
  logic signed [COMP_W-1:0] s6_off;
  logic signed [TEMP_W-1:0] s6_temp;
  logic signed [PROD_W-1:0] prod, p_mid, p_full;

  assign s7_rdy   = !s7_v || out_ready;
  assign s6_rdy   = !s6_v || s7_rdy;
  assign in_ready = s6_rdy;

  // Split SENS into an unsigned low slice and a signed high slice
  assign s6_lo_next = in_data.d1 * in_data.sens[SPLIT_W-1:0];
  assign s6_hi_next = $signed({1'b0, in_data.d1})
                    * $signed(in_data.sens[COMP_W-1:SPLIT_W]);

  assign prod   = (PROD_W'(s6_hi) <<< SPLIT_W) + $signed({22'b0, s6_lo});
  assign p_mid  = (prod >>> P_SHIFT_A) - PROD_W'(s6_off);
  assign p_full = p_mid >>> P_SHIFT_B;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
      s7_v <= 1'b0;
    end else begin
      if (s6_rdy) s6_v <= in_valid;
      if (s7_rdy) s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_rdy) begin
      s6_lo   <= s6_lo_next;
      s6_hi   <= s6_hi_next;
      s6_off  <= in_data.off;
      s6_temp <= in_data.temp;
    end
    if (s7_rdy) begin
      temperature_centideg <= s6_temp;
      pressure_pa          <= p_full[P_W-1:0];
    end
  end

  assign out_valid = s7_v;

endmodule
